[sv/wfg_pkg.sv]
package wfg_pkg;

    localparam int TIME_BITS_DEF  = 32;
    localparam int LEVEL_BITS_DEF = 16;

    localparam int MODE_W     = 3;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_AMP    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_HOLD   = 3'd4;

    localparam logic [MODE_W-1:0] MODE_SINE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TRIANGLE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SQUARE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STEP     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PULSE    = 3'd4;

    localparam int NORM_W        = 32;
    localparam int ANG_BITS      = 24;
    localparam int CORDIC_STAGES = 20;
    localparam int CORDIC_XW     = 34;
    localparam int CORDIC_ZW     = 25;
    localparam int Q_FRAC        = 30;
    localparam logic signed [CORDIC_XW-1:0] CORDIC_X0 = 34'sd652032874;

    typedef struct packed {
        logic after;
        logic atleast;
        logic pulse_hit;
        logic sq_hit;
    } t_flags;

    function automatic logic signed [CORDIC_ZW-1:0] cordic_atan(input int idx);
        logic signed [CORDIC_ZW-1:0] v;
        case (idx)
            0:  v = 25'sd2097152;
            1:  v = 25'sd1238021;
            2:  v = 25'sd654136;
            3:  v = 25'sd332050;
            4:  v = 25'sd166669;
            5:  v = 25'sd83416;
            6:  v = 25'sd41718;
            7:  v = 25'sd20860;
            8:  v = 25'sd10430;
            9:  v = 25'sd5215;
            10: v = 25'sd2608;
            11: v = 25'sd1304;
            12: v = 25'sd652;
            13: v = 25'sd326;
            14: v = 25'sd163;
            15: v = 25'sd81;
            16: v = 25'sd41;
            17: v = 25'sd20;
            18: v = 25'sd10;
            19: v = 25'sd5;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[sv/wfg_div_cell.sv]
module wfg_div_cell
    import wfg_pkg::*;
#(
    parameter int W  = 32,
    parameter int DB = 32,
    parameter int SB = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [W-1:0]  i_div,
    input  logic [W-1:0]  i_rem,
    input  logic [DB-1:0] i_data,
    input  logic [SB-1:0] i_side,
    output logic          o_valid,
    output logic [W-1:0]  o_rem,
    output logic [DB-1:0] o_data,
    output logic [SB-1:0] o_side
);

    logic          r_valid;
    logic [W-1:0]  r_rem;
    logic [DB-1:0] r_data;
    logic [SB-1:0] r_side;
    logic [W:0]    trial;
    logic          ge;
    logic [W-1:0]  n_rem;

    always_comb begin
        trial = {i_rem, i_data[DB-1]};
        ge    = trial >= {1'b0, i_div};
        n_rem = ge ? W'(trial - {1'b0, i_div}) : W'(trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_rem  <= n_rem;
        r_data <= {i_data[DB-2:0], ge};
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_data  = r_data;
    assign o_side  = r_side;

endmodule

[sv/wfg_cordic_cell.sv]
module wfg_cordic_cell
    import wfg_pkg::*;
#(
    parameter int I  = 0,
    parameter int SB = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic signed [CORDIC_XW-1:0] i_x,
    input  logic signed [CORDIC_XW-1:0] i_y,
    input  logic signed [CORDIC_ZW-1:0] i_z,
    input  logic [SB-1:0]               i_side,
    output logic                        o_valid,
    output logic signed [CORDIC_XW-1:0] o_x,
    output logic signed [CORDIC_XW-1:0] o_y,
    output logic signed [CORDIC_ZW-1:0] o_z,
    output logic [SB-1:0]               o_side
);

    localparam logic signed [CORDIC_ZW-1:0] ATAN = cordic_atan(I);

    logic                        r_valid;
    logic signed [CORDIC_XW-1:0] r_x, r_y;
    logic signed [CORDIC_ZW-1:0] r_z;
    logic [SB-1:0]               r_side;
    logic signed [CORDIC_XW-1:0] dx, dy;

    assign dx = i_y >>> I;
    assign dy = i_x >>> I;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        if (!i_z[CORDIC_ZW-1]) begin
            r_x <= i_x - dx;
            r_y <= i_y + dy;
            r_z <= i_z - ATAN;
        end else begin
            r_x <= i_x + dx;
            r_y <= i_y - dy;
            r_z <= i_z + ATAN;
        end
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

[sv/waveform_function_generator.sv]
// Channel   | Direction | Signals                       | Transfer
// command   | in        | i_start, i_time_value, o_busy | i_start high, o_busy low
// config    | in        | i_cfg_we, i_cfg_addr, i_cfg_data | i_cfg_we high, no wait
// result    | out       | o_valid, o_level              | one cycle, o_valid high
//
// One transaction per clock; o_busy is always low.
// The pipeline runs through the modulo divider cells (one per time bit), the
// triangle divider cells (one per level bit), 24 angle divider cells and 20
// CORDIC cells.
// Synchronous active-low reset clears valid bits and loads register reset values.
// Results cannot be stalled by the receiver.
module waveform_function_generator
    import wfg_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [TIME_BITS-1:0]                 i_time_value,
    output logic                                 o_busy,
    input  logic                                 i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]                i_cfg_addr,
    input  logic [((TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS)-1:0] i_cfg_data,
    output logic                                 o_valid,
    output logic signed [LEVEL_BITS-1:0]         o_level
);

    localparam int TW  = TIME_BITS;
    localparam int LW  = LEVEL_BITS;
    localparam int NW  = (TW > NORM_W) ? NORM_W : TW;
    localparam int KW  = $clog2(TW) + 1;
    localparam int DW  = LW + NW;
    localparam int FW  = $bits(t_flags);
    localparam int MW  = LW + Q_FRAC + 1;
    localparam int LAT = TW + LW + ANG_BITS + CORDIC_STAGES + 5;

    // configuration
    logic [MODE_W-1:0]    r_mode;
    logic signed [LW-1:0] r_amp;
    logic [TW-1:0]        r_offset, r_period, r_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_SINE;
            r_amp    <= '0;
            r_offset <= '0;
            r_period <= TW'(1);
            r_hold   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MODE:   r_mode   <= i_cfg_data[MODE_W-1:0];
                REG_AMP:    r_amp    <= i_cfg_data[LW-1:0];
                REG_OFFSET: r_offset <= i_cfg_data[TW-1:0];
                REG_PERIOD: r_period <= i_cfg_data[TW-1:0];
                REG_HOLD:   r_hold   <= i_cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    logic [TW-1:0] per_eff;
    logic [KW-1:0] norm_k;
    logic [NW-1:0] per_n;
    logic [LW-1:0] amp_mag;

    always_comb begin
        per_eff = (r_period == '0) ? TW'(1) : r_period;
        norm_k  = '0;
        for (int i = 0; i < TW; i++) begin
            if (i >= NORM_W && per_eff[i]) begin
                norm_k = KW'(i - NORM_W + 1);
            end
        end
        per_n   = NW'(per_eff >> norm_k);
        amp_mag = r_amp[LW-1] ? LW'(-r_amp) : r_amp;
    end

    assign o_busy = 1'b0;

    // input stage
    logic          r_s0_valid;
    logic [TW-1:0] r_s0_d;
    t_flags        r_s0_flags;
    logic [TW-1:0] in_d;

    assign in_d = i_time_value - r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= i_start;
        end
        r_s0_d                <= in_d;
        r_s0_flags.after      <= i_time_value > r_offset;
        r_s0_flags.atleast    <= i_time_value >= r_offset;
        r_s0_flags.pulse_hit  <= (i_time_value >= r_offset) && (in_d <= r_hold);
        r_s0_flags.sq_hit     <= 1'b0;
    end

    // phase: d mod period
    logic          mod_v    [0:TW];
    logic [TW-1:0] mod_rem  [0:TW];
    logic [TW-1:0] mod_data [0:TW];
    logic [FW-1:0] mod_side [0:TW];

    assign mod_v[0]    = r_s0_valid;
    assign mod_rem[0]  = '0;
    assign mod_data[0] = r_s0_d;
    assign mod_side[0] = r_s0_flags;

    for (genvar g = 0; g < TW; g++) begin : g_mod
        wfg_div_cell #(.W(TW), .DB(TW), .SB(FW)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(mod_v[g]),
            .i_div  (per_eff),
            .i_rem  (mod_rem[g]),
            .i_data (mod_data[g]),
            .i_side (mod_side[g]),
            .o_valid(mod_v[g+1]),
            .o_rem  (mod_rem[g+1]),
            .o_data (mod_data[g+1]),
            .o_side (mod_side[g+1])
        );
    end

    // normalize phase, triangle ramp
    logic [TW-1:0] ph;
    logic [TW:0]   tri_r;
    logic [NW-1:0] n_pn, n_rn;
    t_flags        n_p1_flags;

    always_comb begin
        ph    = mod_rem[TW];
        tri_r = (ph < per_eff - ph) ? {ph, 1'b0} : {per_eff - ph, 1'b0};
        n_pn  = NW'(ph >> norm_k);
        if (n_pn >= per_n) begin
            n_pn = per_n - NW'(1);
        end
        n_rn  = NW'(tri_r >> norm_k);
        if (n_rn > per_n) begin
            n_rn = per_n;
        end
        n_p1_flags        = mod_side[TW];
        n_p1_flags.sq_hit = n_p1_flags.after && (ph < r_hold);
    end

    logic          r_p1_valid;
    logic [NW-1:0] r_p1_pn, r_p1_rn;
    t_flags        r_p1_flags;

    logic          r_p2_valid;
    logic [DW-1:0] r_p2_prod;
    logic [NW-1:0] r_p2_pn;
    t_flags        r_p2_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else begin
            r_p1_valid <= mod_v[TW];
            r_p2_valid <= r_p1_valid;
        end
        r_p1_pn    <= n_pn;
        r_p1_rn    <= n_rn;
        r_p1_flags <= n_p1_flags;
        r_p2_prod  <= DW'(amp_mag) * DW'(r_p1_rn) + DW'(per_n >> 1);
        r_p2_pn    <= r_p1_pn;
        r_p2_flags <= r_p1_flags;
    end

    // triangle quotient
    localparam int TSB = FW + NW;
    logic          tri_v    [0:LW];
    logic [NW-1:0] tri_rem  [0:LW];
    logic [LW-1:0] tri_data [0:LW];
    logic [TSB-1:0] tri_side [0:LW];

    assign tri_v[0]    = r_p2_valid;
    assign tri_rem[0]  = r_p2_prod[DW-1:LW];
    assign tri_data[0] = r_p2_prod[LW-1:0];
    assign tri_side[0] = {r_p2_flags, r_p2_pn};

    for (genvar g = 0; g < LW; g++) begin : g_tri
        wfg_div_cell #(.W(NW), .DB(LW), .SB(TSB)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(tri_v[g]),
            .i_div  (per_n),
            .i_rem  (tri_rem[g]),
            .i_data (tri_data[g]),
            .i_side (tri_side[g]),
            .o_valid(tri_v[g+1]),
            .o_rem  (tri_rem[g+1]),
            .o_data (tri_data[g+1]),
            .o_side (tri_side[g+1])
        );
    end

    // sine angle in 2^-24 turn
    localparam int ASB = FW + LW;
    logic                ang_v    [0:ANG_BITS];
    logic [NW-1:0]       ang_rem  [0:ANG_BITS];
    logic [ANG_BITS-1:0] ang_data [0:ANG_BITS];
    logic [ASB-1:0]      ang_side [0:ANG_BITS];

    assign ang_v[0]    = tri_v[LW];
    assign ang_rem[0]  = tri_side[LW][NW-1:0];
    assign ang_data[0] = '0;
    assign ang_side[0] = {tri_side[LW][TSB-1:NW], tri_data[LW]};

    for (genvar g = 0; g < ANG_BITS; g++) begin : g_ang
        wfg_div_cell #(.W(NW), .DB(ANG_BITS), .SB(ASB)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(ang_v[g]),
            .i_div  (per_n),
            .i_rem  (ang_rem[g]),
            .i_data (ang_data[g]),
            .i_side (ang_side[g]),
            .o_valid(ang_v[g+1]),
            .o_rem  (ang_rem[g+1]),
            .o_data (ang_data[g+1]),
            .o_side (ang_side[g+1])
        );
    end

    // CORDIC rotation
    localparam int CSB = ASB + 2;
    logic                        cor_v    [0:CORDIC_STAGES];
    logic signed [CORDIC_XW-1:0] cor_x    [0:CORDIC_STAGES];
    logic signed [CORDIC_XW-1:0] cor_y    [0:CORDIC_STAGES];
    logic signed [CORDIC_ZW-1:0] cor_z    [0:CORDIC_STAGES];
    logic [CSB-1:0]              cor_side [0:CORDIC_STAGES];

    assign cor_v[0]    = ang_v[ANG_BITS];
    assign cor_x[0]    = CORDIC_X0;
    assign cor_y[0]    = '0;
    assign cor_z[0]    = CORDIC_ZW'(ang_data[ANG_BITS][ANG_BITS-3:0]);
    assign cor_side[0] = {ang_side[ANG_BITS], ang_data[ANG_BITS][ANG_BITS-1:ANG_BITS-2]};

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cor
        wfg_cordic_cell #(.I(g), .SB(CSB)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(cor_v[g]),
            .i_x    (cor_x[g]),
            .i_y    (cor_y[g]),
            .i_z    (cor_z[g]),
            .i_side (cor_side[g]),
            .o_valid(cor_v[g+1]),
            .o_x    (cor_x[g+1]),
            .o_y    (cor_y[g+1]),
            .o_z    (cor_z[g+1]),
            .o_side (cor_side[g+1])
        );
    end

    // quadrant select, clamp, scale by amplitude
    localparam logic signed [CORDIC_XW-1:0] ONE_Q = CORDIC_XW'(1) <<< Q_FRAC;

    logic [1:0]                  quad;
    logic signed [CORDIC_XW-1:0] s_sel;
    logic                        s_neg;
    logic [Q_FRAC:0]             s_mag;
    logic [MW-1:0]               s_prod;

    always_comb begin
        quad = cor_side[CORDIC_STAGES][1:0];
        case (quad)
            2'd0:    s_sel = cor_y[CORDIC_STAGES];
            2'd1:    s_sel = cor_x[CORDIC_STAGES];
            2'd2:    s_sel = -cor_y[CORDIC_STAGES];
            default: s_sel = -cor_x[CORDIC_STAGES];
        endcase
        if (s_sel > ONE_Q) begin
            s_sel = ONE_Q;
        end
        if (s_sel < -ONE_Q) begin
            s_sel = -ONE_Q;
        end
        s_neg  = s_sel[CORDIC_XW-1];
        s_mag  = s_neg ? (Q_FRAC+1)'(-s_sel) : (Q_FRAC+1)'(s_sel);
        s_prod = MW'(amp_mag) * MW'(s_mag) + (MW'(1) << (Q_FRAC - 1));
    end

    logic          r_m_valid;
    logic [LW-1:0] r_m_sq;
    logic          r_m_sneg;
    logic [LW-1:0] r_m_tq;
    t_flags        r_m_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= cor_v[CORDIC_STAGES];
        end
        r_m_sq    <= s_prod[Q_FRAC +: LW];
        r_m_sneg  <= s_neg;
        r_m_tq    <= cor_side[CORDIC_STAGES][LW+1:2];
        r_m_flags <= cor_side[CORDIC_STAGES][CSB-1:LW+2];
    end

    // output
    logic                 r_out_valid;
    logic signed [LW-1:0] r_out_level;
    logic signed [LW-1:0] n_level;

    always_comb begin
        n_level = '0;
        case (r_mode)
            MODE_SINE: begin
                if (r_m_flags.after) begin
                    n_level = (r_m_sneg ^ r_amp[LW-1]) ? -r_m_sq : r_m_sq;
                end
            end
            MODE_TRIANGLE: begin
                if (r_m_flags.after) begin
                    n_level = r_amp[LW-1] ? -r_m_tq : r_m_tq;
                end
            end
            MODE_SQUARE: begin
                if (r_m_flags.sq_hit) begin
                    n_level = r_amp;
                end
            end
            MODE_STEP: begin
                if (r_m_flags.atleast) begin
                    n_level = r_amp;
                end
            end
            MODE_PULSE: begin
                if (r_m_flags.pulse_hit) begin
                    n_level = r_amp;
                end
            end
            default: n_level = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_m_valid;
        end
        r_out_level <= n_level;
    end

    assign o_valid = r_out_valid;
    assign o_level = r_out_level;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##LAT o_valid)
        else $error("result missing after fixed latency");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, LAT))
        else $error("result without transaction");

    a_step_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_mode == MODE_STEP) |-> (o_level == r_amp || o_level == '0))
        else $error("step level neither amplitude nor zero");

    a_unused_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_mode != MODE_SINE && r_mode != MODE_TRIANGLE
         && r_mode != MODE_SQUARE && r_mode != MODE_STEP && r_mode != MODE_PULSE)
        |-> (o_level == '0))
        else $error("unused mode gave nonzero level");

endmodule

[sim/waveform_function_generator_tb.sv]
`timescale 1ns / 100ps

module waveform_function_generator_tb;
    import wfg_pkg::*;

    localparam int TW = 32;
    localparam int LW = 16;
    localparam int CLK_HALF = 4;
    localparam int DRAIN_CYCLES = TW + LW + 60;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_DIRECTED = 20;
    localparam int N_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 40;
    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;
    localparam logic [TW-1:0] TMAX = '1;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic signed [LW-1:0] amp;
        logic [TW-1:0] offset;
        logic [TW-1:0] period;
        logic [TW-1:0] hold;
        logic [TW-1:0] tval;
        bit known;
        logic signed [LW-1:0] level;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    logic [TW-1:0] i_time_value;
    logic o_busy;
    logic i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [TW-1:0] i_cfg_data;
    logic o_valid;
    logic signed [LW-1:0] o_level;

    logic [MODE_W-1:0] cur_mode;
    logic signed [LW-1:0] cur_amp;
    logic [TW-1:0] cur_offset;
    logic [TW-1:0] cur_period;
    logic [TW-1:0] cur_hold;

    logic signed [LW-1:0] level_q[$];
    t_stim_row dir_tbl[N_DIRECTED];
    longint atan_lut[20];
    int n_errors;
    int n_checked;
    int n_sent;
    int cycle_cnt;

    waveform_function_generator DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_time_value(i_time_value),
        .o_busy(o_busy),
        .i_cfg_we(i_cfg_we),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_data(i_cfg_data),
        .o_valid(o_valid),
        .o_level(o_level)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt >= CYCLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic longint scale_rnd(longint a, longint num, longint den);
        longint mag;
        longint r;
        mag = (a < 0) ? -a : a;
        r = (mag * num + den / 2) / den;
        return (a < 0) ? -r : r;
    endfunction

    function automatic longint sine_val(longint p, longint per);
        longint ang;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint s;
        int quad;
        x = 652032874;
        y = 0;
        if (p >= per) p = per - 1;
        ang = (p << 24) / per;
        quad = int'((ang >> 22) & 3);
        z = ang & 64'h3FFFFF;
        for (int i = 0; i < 20; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_lut[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atan_lut[i];
            end
        end
        case (quad)
            0: s = y;
            1: s = x;
            2: s = -y;
            default: s = -x;
        endcase
        if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
        if (s < -(64'sd1 <<< 30)) s = -(64'sd1 <<< 30);
        if (s < 0) return -scale_rnd(cur_amp, -s, 64'sd1 <<< 30);
        return scale_rnd(cur_amp, s, 64'sd1 <<< 30);
    endfunction

    function automatic logic signed [LW-1:0] predict_level(logic [TW-1:0] t);
        longint per;
        longint p;
        longint r;
        logic [TW-1:0] d;
        bit after;
        bit atleast;
        longint lv;
        per = (cur_period == 0) ? 1 : longint'(cur_period);
        d = t - cur_offset;
        p = longint'(d) % per;
        after = t > cur_offset;
        atleast = t >= cur_offset;
        lv = 0;
        case (cur_mode)
            MODE_SINE: if (after) lv = sine_val(p, per);
            MODE_TRIANGLE: if (after) begin
                r = (p < per - p) ? 2 * p : 2 * (per - p);
                if (r > per) r = per;
                lv = scale_rnd(cur_amp, r, per);
            end
            MODE_SQUARE: if (after && p < longint'(cur_hold)) lv = cur_amp;
            MODE_STEP: if (atleast) lv = cur_amp;
            MODE_PULSE: if (atleast && d <= cur_hold) lv = cur_amp;
            default: lv = 0;
        endcase
        return lv[LW-1:0];
    endfunction

    function automatic t_stim_row mk_row(logic [MODE_W-1:0] mode, logic signed [LW-1:0] amp,
                                         logic [TW-1:0] offset, logic [TW-1:0] period,
                                         logic [TW-1:0] hold, logic [TW-1:0] tval,
                                         bit known, logic signed [LW-1:0] level);
        t_stim_row r;
        r.mode = mode;
        r.amp = amp;
        r.offset = offset;
        r.period = period;
        r.hold = hold;
        r.tval = tval;
        r.known = known;
        r.level = level;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (level_q.size() == 0) begin
                $error("unexpected result: level actual %0d", o_level);
                n_errors++;
            end else begin
                if (o_level !== level_q[0]) begin
                    $error("level mismatch: expected %0d actual %0d", level_q[0], o_level);
                    n_errors++;
                end
                void'(level_q.pop_front());
                n_checked++;
            end
        end
    end

    task automatic idle_cycles(int n);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (level_q.size() != 0) @(posedge i_clk);
        idle_cycles(4);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [TW-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_MODE: cur_mode = data[MODE_W-1:0];
            REG_AMP: cur_amp = data[LW-1:0];
            REG_OFFSET: cur_offset = data;
            REG_PERIOD: cur_period = data;
            REG_HOLD: cur_hold = data;
            default: ;
        endcase
    endtask

    task automatic load_setting(logic [MODE_W-1:0] mode, logic signed [LW-1:0] amp,
                                logic [TW-1:0] offset, logic [TW-1:0] period,
                                logic [TW-1:0] hold);
        if (mode != cur_mode || amp != cur_amp || offset != cur_offset ||
            period != cur_period || hold != cur_hold) begin
            drain();
            if (mode != cur_mode) write_reg(REG_MODE, TW'({$urandom(), mode}));
            if (amp != cur_amp) write_reg(REG_AMP, TW'({$urandom_range(0, 16'hFFFF), amp}));
            if (offset != cur_offset) write_reg(REG_OFFSET, offset);
            if (period != cur_period) write_reg(REG_PERIOD, period);
            if (hold != cur_hold) write_reg(REG_HOLD, hold);
        end
    endtask

    task automatic issue_time(logic [TW-1:0] t, bit known, logic signed [LW-1:0] lvl, int gap);
        i_start <= 1'b1;
        i_time_value <= t;
        do @(posedge i_clk); while (o_busy);
        level_q.push_back(known ? lvl : predict_level(t));
        n_sent++;
        if (gap > 0) begin
            i_start <= 1'b0;
            idle_cycles(gap);
        end
    endtask

    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [TW-1:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 0;
        if (r < 16) return 1;
        if (r < 24) return TMAX;
        if (r < 80) return $urandom_range(2, 200);
        return $urandom();
    endfunction

    initial begin
        logic [TW-1:0] per;
        logic [TW-1:0] off;
        logic [TW-1:0] t;
        logic [MODE_W-1:0] mode;
        logic signed [LW-1:0] amp;
        bit quiet;
        longint span;

        atan_lut = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
                     10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};
        n_errors = 0;
        n_checked = 0;
        n_sent = 0;
        cur_mode = MODE_SINE;
        cur_amp = '0;
        cur_offset = '0;
        cur_period = 1;
        cur_hold = '0;

        dir_tbl[0]  = mk_row(MODE_SINE, 0, 0, 1, 0, 0, 1, 0);
        dir_tbl[1]  = mk_row(MODE_SINE, 32767, 0, 4, 0, 1, 0, 0);
        dir_tbl[2]  = mk_row(MODE_SINE, 32767, 0, 4, 0, 2, 0, 0);
        dir_tbl[3]  = mk_row(MODE_SINE, 32767, 0, 4, 0, 3, 0, 0);
        dir_tbl[4]  = mk_row(MODE_SINE, 32767, 0, 4, 0, 0, 1, 0);
        dir_tbl[5]  = mk_row(MODE_TRIANGLE, -32768, 0, 8, 0, 4, 0, 0);
        dir_tbl[6]  = mk_row(MODE_TRIANGLE, -32768, 0, TMAX, 0, TMAX, 0, 0);
        dir_tbl[7]  = mk_row(MODE_SQUARE, 32767, 0, 10, 0, 5, 1, 0);
        dir_tbl[8]  = mk_row(MODE_SQUARE, 32767, 0, 10, 3, 2, 1, 32767);
        dir_tbl[9]  = mk_row(MODE_SQUARE, 32767, 0, 10, 3, 13, 1, 0);
        dir_tbl[10] = mk_row(MODE_STEP, -32768, 100, 10, 3, 100, 1, -32768);
        dir_tbl[11] = mk_row(MODE_STEP, -32768, 100, 10, 3, 99, 1, 0);
        dir_tbl[12] = mk_row(MODE_STEP, -32768, 100, 10, 3, TMAX, 1, -32768);
        dir_tbl[13] = mk_row(MODE_PULSE, 1234, 100, 10, 5, 105, 1, 1234);
        dir_tbl[14] = mk_row(MODE_PULSE, 1234, 100, 10, 5, 106, 1, 0);
        dir_tbl[15] = mk_row(MODE_PULSE, 1234, TMAX - 15, 10, TMAX, TMAX, 1, 1234);
        dir_tbl[16] = mk_row(MODE_UNUSED_LO, 500, 0, 10, 5, 7, 1, 0);
        dir_tbl[17] = mk_row(MODE_UNUSED_HI, 500, 0, 10, 5, 0, 1, 0);
        dir_tbl[18] = mk_row(MODE_SINE, 32767, 0, 0, 5, 123, 0, 0);
        dir_tbl[19] = mk_row(MODE_SINE, -32768, 0, TMAX, 5, 32'h3FFF_FFFF, 0, 0);

        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_time_value = '0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[k]) begin
            load_setting(dir_tbl[k].mode, dir_tbl[k].amp, dir_tbl[k].offset,
                         dir_tbl[k].period, dir_tbl[k].hold);
            issue_time(dir_tbl[k].tval, dir_tbl[k].known, dir_tbl[k].level, pick_gap(0));
        end
        i_start <= 1'b0;

        // writes to an unmapped index must leave the registers alone
        drain();
        write_reg(REG_UNMAPPED, $urandom());
        issue_time(40, 0, 0, 0);
        issue_time(0, 0, 0, 1);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            i_start <= 1'b0;
            mode = (ph < 5) ? MODE_W'(ph) : MODE_W'($urandom_range(0, 7));
            case (ph % 4)
                0: amp = 16'sh7FFF;
                1: amp = 16'sh8000;
                default: amp = LW'($urandom());
            endcase
            case ($urandom_range(0, 4))
                0: off = 0;
                1: off = TMAX - $urandom_range(0, 500);
                2: off = $urandom();
                default: off = $urandom_range(0, 1000);
            endcase
            per = pick_period();
            load_setting(mode, amp, off, per, '0);
            if ($urandom_range(0, 3) == 0) write_reg(REG_HOLD, $urandom());
            else if ($urandom_range(0, 1) == 0) write_reg(REG_HOLD, TMAX);
            else write_reg(REG_HOLD, $urandom_range(0, (per == 0) ? 4 : per + 2));
            quiet = (ph % 3 == 2);
            span = (cur_period == 0) ? 8 : longint'(cur_period) * 3;
            if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                case ($urandom_range(0, 9))
                    0, 1: t = $urandom();
                    2: t = cur_offset - $urandom_range(0, 3);
                    default: t = cur_offset + TW'($urandom_range(0, 32'(span)));
                endcase
                issue_time(t, 0, 0, pick_gap(quiet));
            end
        end
        i_start <= 1'b0;

        while (level_q.size() != 0) @(posedge i_clk);
        idle_cycles(DRAIN_CYCLES);
        $display("Covered %0d transactions (%0d results checked) over all wave modes,",
                 n_sent, n_checked);
        $display("amplitude and period extremes, offsets and unmapped register writes.");
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[files.f]
sv/wfg_pkg.sv
sv/wfg_div_cell.sv
sv/wfg_cordic_cell.sv
sv/waveform_function_generator.sv
sim/waveform_function_generator_tb.sv
